// File: rtl/olst_pkg.sv
// ----------------------------------------------------------------------------
// olst_pkg: shared constants and types for the ordered list engine
// Command codes, widths and the control bundle that goes to every cell.
// ----------------------------------------------------------------------------
package olst_pkg;

	localparam int DEPTH   = 64;
	localparam int DATA_W  = 32;
	localparam int POS_W   = 7;
	localparam int CMD_W   = 3;
	localparam int GRP_N   = 8;
	localparam int GRP_CNT = DEPTH / GRP_N;
	localparam int OFF_W   = $clog2(GRP_N);

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

	// control bundle broadcast to the cell row
	typedef struct packed {
		logic              shift_up;  // insert: open a slot at pos_idx
		logic              shift_dn;  // delete: close the slot at pos_idx
		logic [POS_W-1:0]  pos_idx;   // 0-based position
		logic [DATA_W-1:0] key;       // insert value / locate key
		logic [POS_W-1:0]  count;     // live element count
	} cell_ctrl_t;

endpackage

// File: rtl/olst_cell.sv
// ----------------------------------------------------------------------------
// olst_cell: one list slot
// Holds one element, shifts from either neighbor, compares against the key.
// ----------------------------------------------------------------------------
module olst_cell (
	input  logic                              clk,
	input  olst_pkg::cell_ctrl_t              ctrl,
	input  logic [olst_pkg::POS_W-1:0]        idx,
	input  logic [olst_pkg::DATA_W-1:0]       left_d,
	input  logic [olst_pkg::DATA_W-1:0]       right_d,
	output logic [olst_pkg::DATA_W-1:0]       q,
	output logic                              match,
	output logic [olst_pkg::DATA_W-1:0]       sel_d
);

	logic [olst_pkg::DATA_W-1:0] data_q;
	logic                        at_pos;
	logic                        above_pos;

	assign at_pos    = (idx == ctrl.pos_idx);
	assign above_pos = (idx > ctrl.pos_idx);

	always_ff @(posedge clk) begin
		if (ctrl.shift_up) begin
			if (above_pos) begin
				data_q <= left_d;
			end else if (at_pos) begin
				data_q <= ctrl.key;
			end
		end else if (ctrl.shift_dn) begin
			if (above_pos || at_pos) begin
				data_q <= right_d;
			end
		end
	end

	assign q     = data_q;
	assign match = (data_q == ctrl.key) && (idx < ctrl.count);
	assign sel_d = at_pos ? data_q : '0;

endmodule

// File: rtl/olst_group.sv
// ----------------------------------------------------------------------------
// olst_group: first-match and read-select over one group of cells
// Registered partial result; the top level merges the groups.
// ----------------------------------------------------------------------------
module olst_group (
	input  logic                                          clk,
	input  logic [olst_pkg::GRP_N-1:0]                    match,
	input  logic [olst_pkg::GRP_N-1:0][olst_pkg::DATA_W-1:0] sel_d,
	output logic                                          hit_q,
	output logic [olst_pkg::OFF_W-1:0]                    off_q,
	output logic [olst_pkg::DATA_W-1:0]                   data_q
);

	logic                        hit;
	logic [olst_pkg::OFF_W-1:0]  off;
	logic [olst_pkg::DATA_W-1:0] data;

	// lowest matching slot wins
	always_comb begin
		hit  = 1'b0;
		off  = '0;
		data = '0;
		for (int i = olst_pkg::GRP_N - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit = 1'b1;
				off = olst_pkg::OFF_W'(i);
			end
			data = data | sel_d[i];
		end
	end

	always_ff @(posedge clk) begin
		hit_q  <= hit;
		off_q  <= off;
		data_q <= data;
	end

endmodule

// File: rtl/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine: ordered list of signed 32-bit elements
// Row of shifting cells with a two-level registered search/read tree.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive command/position/value and raise start; the item
//   is taken at a clock edge with start high and busy low.
//   Result channel: done is high for exactly one cycle with ok, element,
//   found_at, count and empty_res valid; the receiver cannot stall it.
// Sequence: accept edge, the execute cycle (cells shift, groups compare and
//   select), the merge cycle across the groups; done shows in the cycle
//   after the merge.
// Items do not overlap: busy is high during execute and merge, and a new
//   item may be taken while done is shown. The spacing of items is set by
//   the per-group registered search stage followed by the merge.
// Insert shifts every cell above the position up by one during execute;
// delete shifts them down. Clear only resets the count; slots keep data.
// Reset: count goes to zero and the sequencer to idle; slot contents are
// left as they are since only slots below the count are ever looked at.
// ----------------------------------------------------------------------------
module ordered_list_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [olst_pkg::CMD_W-1:0]        command,
	input  logic [olst_pkg::POS_W-1:0]        position,
	input  logic signed [olst_pkg::DATA_W-1:0] value,
	output logic                              done,
	output logic                              ok,
	output logic signed [olst_pkg::DATA_W-1:0] element,
	output logic [olst_pkg::POS_W-1:0]        found_at,
	output logic [olst_pkg::POS_W-1:0]        count,
	output logic                              empty_res
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_REDUCE = 2'd2;

	logic [1:0]                    state_q;
	logic                          done_q;
	logic [olst_pkg::POS_W-1:0]    count_q;

	// captured command item
	logic [olst_pkg::CMD_W-1:0]    cmd_q;
	logic [olst_pkg::POS_W-1:0]    pos_q;
	logic [olst_pkg::DATA_W-1:0]   val_q;
	logic                          res_ok_q;

	// result registers
	logic                          ok_q;
	logic [olst_pkg::DATA_W-1:0]   elem_q;
	logic [olst_pkg::POS_W-1:0]    found_q;

	// cell row
	olst_pkg::cell_ctrl_t          ctrl;
	logic [olst_pkg::DEPTH-1:0][olst_pkg::DATA_W-1:0] cell_q;
	logic [olst_pkg::DEPTH-1:0][olst_pkg::DATA_W-1:0] cell_sel;
	logic [olst_pkg::DEPTH-1:0]    cell_match;

	// group partials
	logic [olst_pkg::GRP_CNT-1:0]  grp_hit;
	logic [olst_pkg::GRP_CNT-1:0][olst_pkg::OFF_W-1:0]  grp_off;
	logic [olst_pkg::GRP_CNT-1:0][olst_pkg::DATA_W-1:0] grp_data;

	// execute-cycle decode
	logic                          pos_nz;
	logic                          rd_ok;
	logic                          ins_ok;
	logic                          cmd_ok;
	logic [olst_pkg::POS_W-1:0]    count_nxt;

	// merge-cycle decode
	logic                          any_hit;
	logic [olst_pkg::POS_W-1:0]    hit_idx;
	logic [olst_pkg::DATA_W-1:0]   rd_data;

	assign pos_nz = (pos_q != '0);
	assign rd_ok  = pos_nz && (pos_q <= count_q);
	assign ins_ok = pos_nz && ({1'b0, pos_q} <= ({1'b0, count_q} + 8'd1))
		&& (count_q < olst_pkg::POS_W'(olst_pkg::DEPTH));

	always_comb begin
		cmd_ok    = 1'b0;
		count_nxt = count_q;
		unique case (cmd_q)
			olst_pkg::CMD_CLEAR: begin
				cmd_ok    = 1'b1;
				count_nxt = '0;
			end
			olst_pkg::CMD_GET: begin
				cmd_ok = rd_ok;
			end
			olst_pkg::CMD_LOCATE: begin
				cmd_ok = 1'b1;
			end
			olst_pkg::CMD_INSERT: begin
				cmd_ok = ins_ok;
				if (ins_ok) begin
					count_nxt = count_q + 1'b1;
				end
			end
			olst_pkg::CMD_DELETE: begin
				cmd_ok = rd_ok;
				if (rd_ok) begin
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
				cmd_ok = 1'b0;
			end
		endcase
	end

	// cells act only in the execute cycle
	assign ctrl.shift_up = (state_q == ST_EXEC) && (cmd_q == olst_pkg::CMD_INSERT) && ins_ok;
	assign ctrl.shift_dn = (state_q == ST_EXEC) && (cmd_q == olst_pkg::CMD_DELETE) && rd_ok;
	assign ctrl.pos_idx  = pos_q - 1'b1;
	assign ctrl.key      = val_q;
	assign ctrl.count    = count_q;

	for (genvar i = 0; i < olst_pkg::DEPTH; i++) begin : g_cell
		logic [olst_pkg::DATA_W-1:0] left_d;
		logic [olst_pkg::DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_q[i-1];
		end
		if (i == olst_pkg::DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_q[i+1];
		end
		olst_cell u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.idx     (olst_pkg::POS_W'(i)),
			.left_d  (left_d),
			.right_d (right_d),
			.q       (cell_q[i]),
			.match   (cell_match[i]),
			.sel_d   (cell_sel[i])
		);
	end

	for (genvar g = 0; g < olst_pkg::GRP_CNT; g++) begin : g_grp
		olst_group u_group (
			.clk    (clk),
			.match  (cell_match[g*olst_pkg::GRP_N +: olst_pkg::GRP_N]),
			.sel_d  (cell_sel[g*olst_pkg::GRP_N +: olst_pkg::GRP_N]),
			.hit_q  (grp_hit[g]),
			.off_q  (grp_off[g]),
			.data_q (grp_data[g])
		);
	end

	// merge: lowest hit group, OR of group read data
	always_comb begin
		any_hit = 1'b0;
		hit_idx = '0;
		rd_data = '0;
		for (int g = olst_pkg::GRP_CNT - 1; g >= 0; g--) begin
			if (grp_hit[g]) begin
				any_hit = 1'b1;
				hit_idx = olst_pkg::POS_W'(g * olst_pkg::GRP_N)
					+ olst_pkg::POS_W'(grp_off[g]);
			end
			rd_data = rd_data | grp_data[g];
		end
	end

	// sequencer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					count_q <= count_nxt;
					state_q <= ST_REDUCE;
				end
				ST_REDUCE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item capture and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= command;
			pos_q <= position;
			val_q <= value;
		end
		if (state_q == ST_EXEC) begin
			res_ok_q <= cmd_ok;
		end
		if (state_q == ST_REDUCE) begin
			ok_q    <= res_ok_q;
			elem_q  <= (res_ok_q && (cmd_q == olst_pkg::CMD_GET
				|| cmd_q == olst_pkg::CMD_DELETE)) ? rd_data : '0;
			found_q <= (cmd_q == olst_pkg::CMD_LOCATE && any_hit)
				? hit_idx + 1'b1 : '0;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign ok        = ok_q;
	assign element   = elem_q;
	assign found_at  = found_q;
	assign count     = count_q;
	assign empty_res = (count_q == '0);

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= olst_pkg::POS_W'(olst_pkg::DEPTH))
		else $error("element count above capacity");

	a_done_after_merge: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_REDUCE))
		else $error("result strobe without merge cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item did not make block busy");

	a_found_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found_at != '0) |-> (found_at <= count))
		else $error("locate hit beyond element count");

endmodule

// File: sim/ordered_list_engine_tb.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_tb: self-checking bench for the ordered list engine
// Drives list commands through the start/busy port and keeps a shadow copy of
// the list to work out each expected result. Every done strobe is checked
// field by field against the oldest pending result. Directed corner cases run
// first, then random command streams that grow, fill, churn and drain the list.
// ----------------------------------------------------------------------------
module ordered_list_engine_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import olst_pkg::*;

	localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
	localparam int CMD_LAST = (2 ** CMD_W) - 1;

	// one result item as the block reports it
	typedef struct {
		logic                     ok;
		logic signed [DATA_W-1:0] element;
		logic [POS_W-1:0]         found_at;
		logic [POS_W-1:0]         count;
		logic                     empty_res;
	} list_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [CMD_W-1:0]         command;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	logic                     done;
	logic                     ok;
	logic signed [DATA_W-1:0] element;
	logic [POS_W-1:0]         found_at;
	logic [POS_W-1:0]         count;
	logic                     empty_res;

	// shadow list: only entries 0..list_len-1 are ever read
	logic signed [DATA_W-1:0] list_mem [DEPTH];
	int                       list_len;

	list_result_t pending_results[$];
	int           mismatch_cnt;
	bit           no_idle;

	ordered_list_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.position  (position),
		.value     (value),
		.done      (done),
		.ok        (ok),
		.element   (element),
		.found_at  (found_at),
		.count     (count),
		.empty_res (empty_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Shadow list update: applies one command and returns what the block
	// should report for it. Failed commands leave the list untouched.
	// ------------------------------------------------------------------------
	function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] cmd,
			input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] val);
		list_result_t r;
		int p;
		r.ok       = 1'b0;
		r.element  = '0;
		r.found_at = '0;
		p = int'(pos);
		case (cmd)
			CMD_CLEAR: begin
				// count only; stored words stay behind
				list_len = 0;
				r.ok = 1'b1;
			end
			CMD_GET: begin
				if (p >= 1 && p <= list_len) begin
					r.element = list_mem[p-1];
					r.ok = 1'b1;
				end
			end
			CMD_LOCATE: begin
				// first match wins, no match still counts as success
				for (int k = 0; k < list_len; k++) begin
					if (list_mem[k] == val) begin
						r.found_at = POS_W'(k + 1);
						break;
					end
				end
				r.ok = 1'b1;
			end
			CMD_INSERT: begin
				if (p >= 1 && p <= list_len + 1 && list_len < DEPTH) begin
					for (int k = list_len; k > p - 1; k--)
						list_mem[k] = list_mem[k-1];
					list_mem[p-1] = val;
					list_len++;
					r.ok = 1'b1;
				end
			end
			CMD_DELETE: begin
				if (p >= 1 && p <= list_len) begin
					r.element = list_mem[p-1];
					for (int k = p - 1; k + 1 < list_len; k++)
						list_mem[k] = list_mem[k+1];
					list_len--;
					r.ok = 1'b1;
				end
			end
			default: begin
				// unused codes: no effect, ok stays low
			end
		endcase
		r.count     = POS_W'(list_len);
		r.empty_res = (list_len == 0);
		return r;
	endfunction

	// Idle length: mostly short, now and then long. Zero in back-to-back runs.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// start low with junk on the command fields; the block must ignore it
	task automatic idle_gap(input int n);
		repeat (n) begin
			@(negedge clk);
			start    = 1'b0;
			command  = CMD_W'($urandom);
			position = POS_W'($urandom);
			value    = $urandom;
		end
	endtask

	// ------------------------------------------------------------------------
	// Present one item, hold it until the block takes it, then log the
	// expected result. Fields change on the falling edge only.
	// ------------------------------------------------------------------------
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		@(negedge clk);
		start    = 1'b1;
		command  = cmd;
		position = pos;
		value    = val;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(apply_list_command(cmd, pos, val));
		idle_gap(pick_gap());
	endtask

	// ------------------------------------------------------------------------
	// Random item, mostly well formed: positions in range most of the time,
	// locate keys often taken from the list, values often from a small pool
	// so duplicates show up.
	// ------------------------------------------------------------------------
	task automatic pick_item(input int clr_pct, input int ins_pct, input int del_pct,
			output logic [CMD_W-1:0] cmd, output logic [POS_W-1:0] pos,
			output logic signed [DATA_W-1:0] val);
		int r;
		int lim;
		r = $urandom_range(0, 99);
		if (r < clr_pct)
			cmd = CMD_CLEAR;
		else if (r < clr_pct + ins_pct)
			cmd = CMD_INSERT;
		else if (r < clr_pct + ins_pct + del_pct)
			cmd = CMD_DELETE;
		else if (r < 97)
			cmd = $urandom_range(0, 1) ? CMD_GET : CMD_LOCATE;
		else
			cmd = CMD_W'($urandom_range(int'(CMD_DELETE) + 1, CMD_LAST));

		lim = (cmd == CMD_INSERT) ? list_len + 1 : list_len;
		r = $urandom_range(0, 99);
		if (r < 85 && lim >= 1)
			pos = POS_W'($urandom_range(1, lim));
		else if (r < 92)
			pos = POS_W'(lim + 1);
		else if (r < 95)
			pos = '0;
		else
			pos = POS_W'($urandom);

		r = $urandom_range(0, 99);
		if (cmd == CMD_LOCATE && list_len > 0 && r < 60)
			val = list_mem[$urandom_range(0, list_len - 1)];
		else if (r < 75)
			val = $urandom;
		else begin
			case ($urandom_range(0, 4))
				0: val = MAX_VAL;
				1: val = MIN_VAL;
				2: val = -1;
				default: val = $urandom_range(0, 7);
			endcase
		end
	endtask

	task automatic run_random(input int n, input int clr_pct, input int ins_pct,
			input int del_pct);
		logic [CMD_W-1:0]         cmd;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] val;
		repeat (n) begin
			pick_item(clr_pct, ins_pct, del_pct, cmd, pos, val);
			send_item(cmd, pos, val);
		end
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_cnt++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Result checker: one strobe, one item, compared with the oldest pending.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		list_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("done with no result pending");
				mismatch_cnt++;
			end else begin
				want = pending_results.pop_front();
				check_field("ok", want.ok, ok);
				check_field("element", longint'(want.element), longint'(element));
				check_field("found_at", want.found_at, found_at);
				check_field("count", want.count, count);
				check_field("empty_res", want.empty_res, empty_res);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Test cases
	// ------------------------------------------------------------------------

	// every command on an empty list, plus the position extremes
	task automatic test_empty_list();
		send_item(CMD_CLEAR, 0, 0);
		send_item(CMD_GET, 1, 0);
		send_item(CMD_GET, 0, 0);
		send_item(CMD_DELETE, 1, 0);
		send_item(CMD_LOCATE, 0, 0);
		send_item(CMD_INSERT, 0, MAX_VAL);
		send_item(CMD_INSERT, 2, MAX_VAL);
		send_item(CMD_GET, 7'h7f, 0);
	endtask

	// front, end and middle inserts; reads at both ends and one past
	task automatic test_insert_get();
		send_item(CMD_INSERT, 1, MAX_VAL);
		send_item(CMD_INSERT, 2, MIN_VAL);
		send_item(CMD_INSERT, 1, 0);
		send_item(CMD_INSERT, 2, -1);
		send_item(CMD_GET, 1, 0);
		send_item(CMD_GET, 4, 0);
		send_item(CMD_GET, 5, 0);
		send_item(CMD_INSERT, 6, 7);
	endtask

	// duplicate key reports the first position; a missing key reports zero
	task automatic test_locate();
		send_item(CMD_INSERT, 5, MAX_VAL);
		send_item(CMD_LOCATE, 0, MAX_VAL);
		send_item(CMD_LOCATE, 7'h7f, MIN_VAL);
		send_item(CMD_LOCATE, 1, 12345);
	endtask

	task automatic test_delete();
		send_item(CMD_DELETE, 0, 0);
		send_item(CMD_DELETE, 6, 0);
		send_item(CMD_DELETE, 2, 0);
		send_item(CMD_DELETE, 4, 0);
	endtask

	// unused codes do nothing; clear ignores its fields
	task automatic test_unknown_commands();
		for (int c = int'(CMD_DELETE) + 1; c <= CMD_LAST; c++)
			send_item(CMD_W'(c), 1, MIN_VAL);
		send_item(CMD_CLEAR, 7'h7f, MIN_VAL);
		send_item(CMD_GET, 1, 0);
	endtask

	task automatic test_random_mixed();
		run_random(380, 2, 42, 28);
	endtask

	// grow to DEPTH, then churn at the top so inserts hit the full check
	task automatic test_fill_to_capacity();
		send_item(CMD_CLEAR, 0, 0);
		while (list_len < DEPTH) begin
			if ($urandom_range(0, 9) == 0)
				send_item(CMD_GET, POS_W'($urandom_range(0, list_len + 1)), 0);
			else
				send_item(CMD_INSERT, POS_W'($urandom_range(1, list_len + 1)), $urandom);
		end
		send_item(CMD_INSERT, POS_W'(DEPTH + 1), MAX_VAL);
		send_item(CMD_INSERT, 1, MIN_VAL);
		send_item(CMD_GET, POS_W'(DEPTH), 0);
		send_item(CMD_LOCATE, 0, list_mem[DEPTH-1]);
		run_random(70, 0, 55, 15);
	endtask

	// no idling on the command side: every accept slot is used
	task automatic test_back_to_back();
		no_idle = 1'b1;
		run_random(150, 2, 40, 30);
		no_idle = 1'b0;
	endtask

	task automatic test_drain();
		logic [CMD_W-1:0]         cmd;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] val;
		int                       guard;
		guard = 0;
		while (list_len > 0 && guard < 200) begin
			pick_item(0, 10, 60, cmd, pos, val);
			send_item(cmd, pos, val);
			guard++;
		end
		send_item(CMD_DELETE, 1, 0);
		send_item(CMD_LOCATE, 0, 0);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main_seq
		int wait_cycles;
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		command      = CMD_CLEAR;
		position     = '0;
		value        = '0;
		list_len     = 0;
		mismatch_cnt = 0;
		no_idle      = 1'b0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_insert_get();
		test_locate();
		test_delete();
		test_unknown_commands();
		test_random_mixed();
		test_fill_to_capacity();
		test_back_to_back();
		test_drain();

		@(negedge clk);
		start = 1'b0;

		// wait for the pending results; allow plenty of slack
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 100) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (8) @(posedge clk);

		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			mismatch_cnt++;
		end

		if (mismatch_cnt == 0)
			$display("** ordered_list_engine: PASSED **");
		else
			$display("** ordered_list_engine: FAILED **");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin : watchdog
		#3_000_000;
		$display("** ordered_list_engine: FAILED **");
		$finish;
	end

endmodule
